>>> rtl/core/tdpc_pkg.sv
// Shared types and constants for the trial-division prime counter.
// No dependencies; used by tdpc_div and trial_division_prime_counter.
package tdpc_pkg;

	localparam int unsigned IN_W      = 32;
	localparam int unsigned TALLY_W   = 32;
	localparam int unsigned OUT_W     = 40;
	localparam logic [TALLY_W-1:0] TALLY_MAX = '1;
	localparam int unsigned FIRST_DIVISOR = 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT,
		ST_FINISH
	} seq_state_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

>>> rtl/core/trial_division_prime_counter.sv
// Trial-division prime tester with a saturating prime tally.
// One request is accepted at a time; each divisor tried takes one run of the shared
// serial divider, and up to about 2^(VALUE_WIDTH/2) divisors are tried per request.
// A new request is taken only after the last result has entered the output register,
// which waits while the result side stalls. Asynchronous active-low reset clears the
// sequencer, the output valid and the tally. Depends on tdpc_pkg and tdpc_div.
module trial_division_prime_counter #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [tdpc_pkg::IN_W-1:0]  s_tdata,   // [31:0] value
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [tdpc_pkg::OUT_W-1:0] m_tdata    // [0] prime_flag, [32:1] prime_total, rest 0
);

	localparam int unsigned VW = VALUE_WIDTH;

	tdpc_pkg::seq_state_t state_q, state_d;
	tdpc_pkg::div_status_t div_st;

	logic [VW-1:0] n_q;
	logic [VW-1:0] d_q;
	logic          flag_q;
	logic [VW-1:0] quo;
	logic [VW-1:0] rem;
	logic          div_start;
	logic          out_free;
	logic          load_n;
	logic          step_d;
	logic          set_flag;
	logic          flag_val;
	logic          emit;

	logic [tdpc_pkg::TALLY_W-1:0] tally_q;
	logic [tdpc_pkg::TALLY_W-1:0] tally_next;
	logic                         m_valid_q;
	logic                         out_flag_q;
	logic [tdpc_pkg::TALLY_W-1:0] out_total_q;

	tdpc_div #(.VALUE_WIDTH(VW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (n_q),
		.divisor   (d_q),
		.status    (div_st),
		.quotient  (quo),
		.remainder (rem)
	);

	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == tdpc_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tdpc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		load_n    = 1'b0;
		step_d    = 1'b0;
		set_flag  = 1'b0;
		flag_val  = 1'b0;
		emit      = 1'b0;
		unique case (state_q)
			tdpc_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					load_n  = 1'b1;
					state_d = tdpc_pkg::ST_START;
				end
			end
			tdpc_pkg::ST_START: begin
				div_start = 1'b1;
				state_d   = tdpc_pkg::ST_WAIT;
			end
			tdpc_pkg::ST_WAIT: begin
				if (div_st.done) begin
					// past the square root: no divisor found
					priority if (quo < d_q) begin
						set_flag = 1'b1;
						flag_val = 1'b1;
						state_d  = tdpc_pkg::ST_FINISH;
					end else if (rem == '0) begin
						set_flag = 1'b1;
						flag_val = 1'b0;
						state_d  = tdpc_pkg::ST_FINISH;
					end else begin
						step_d  = 1'b1;
						state_d = tdpc_pkg::ST_START;
					end
				end
			end
			tdpc_pkg::ST_FINISH: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = tdpc_pkg::ST_IDLE;
				end
			end
			default: state_d = tdpc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_n) begin
			n_q <= VW'(s_tdata);
			d_q <= VW'(tdpc_pkg::FIRST_DIVISOR);
		end else if (step_d) begin
			d_q <= d_q + VW'(1);
		end
		if (set_flag) begin
			flag_q <= flag_val;
		end
	end

	assign tally_next = (flag_q && tally_q != tdpc_pkg::TALLY_MAX)
		? tally_q + tdpc_pkg::TALLY_W'(1) : tally_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				tally_q   <= tally_next;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_flag_q  <= flag_q;
			out_total_q <= tally_next;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(tdpc_pkg::OUT_W - tdpc_pkg::TALLY_W - 1)'(0), out_total_q, out_flag_q};

`ifndef SYNTHESIS
	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tdpc_pkg::ST_IDLE |-> !div_st.busy)
		else $error("divider running while sequencer idle");
	a_tally_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		##1 tally_q >= $past(tally_q))
		else $error("prime tally decreased");
	a_tally_step: assert property (@(posedge clk) disable iff (!arst_n)
		!emit |=> $stable(tally_q))
		else $error("tally changed without a result");
	a_done_only_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> state_q == tdpc_pkg::ST_WAIT)
		else $error("division finished outside the wait state");
`endif

endmodule

>>> rtl/core/tdpc_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on tdpc_pkg for the status struct.
module tdpc_div #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [VALUE_WIDTH-1:0]     dividend,
	input  logic [VALUE_WIDTH-1:0]     divisor,
	output tdpc_pkg::div_status_t      status,
	output logic [VALUE_WIDTH-1:0]     quotient,
	output logic [VALUE_WIDTH-1:0]     remainder
);

	localparam int unsigned CW = $clog2(VALUE_WIDTH + 1);

	logic [CW-1:0]          cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [VALUE_WIDTH-1:0] dvd_q;
	logic [VALUE_WIDTH-1:0] dsr_q;
	logic [VALUE_WIDTH-1:0] quo_q;
	logic [VALUE_WIDTH-1:0] rem_q;
	logic [VALUE_WIDTH:0]   trial;
	logic [VALUE_WIDTH:0]   diff;
	logic                   fits;

	assign trial = {rem_q, dvd_q[VALUE_WIDTH-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = ~diff[VALUE_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(VALUE_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[VALUE_WIDTH-2:0], 1'b0};
			quo_q <= {quo_q[VALUE_WIDTH-2:0], fits};
			rem_q <= fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quo_q;
	assign remainder   = rem_q;

`ifndef SYNTHESIS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && (dsr_q != '0) |-> rem_q < dsr_q)
		else $error("remainder not below divisor");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("done without a running division");
`endif

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for trial_division_prime_counter: requests go in on the
// s_ stream, results are checked against a trial-division predictor kept here.
// Depends on tdpc_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned VALUE_WIDTH = 32;
	localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_WIDTH);
	localparam int unsigned CYCLE_LIMIT = 10_000_000;
	localparam int unsigned DRAIN_CYCLES = 200;

	typedef struct {
		logic                          flag;
		logic [tdpc_pkg::TALLY_W-1:0]  total;
	} prime_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	logic [tdpc_pkg::IN_W-1:0]  s_tdata = '0;   // [31:0] value
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [tdpc_pkg::OUT_W-1:0] m_tdata;        // [0] prime_flag, [32:1] prime_total

	prime_result_t                 result_q[$];
	logic [tdpc_pkg::TALLY_W-1:0]  prime_count = '0;
	int unsigned                   errors = 0;
	int unsigned                   cycles = 0;
	bit                            idle_on = 1'b1;

	trial_division_prime_counter #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic no_divisor_found(input logic [tdpc_pkg::IN_W-1:0] raw);
		logic [63:0] n;
		logic [63:0] d;
		n = 64'(raw) & VALUE_MASK;
		d = 64'(tdpc_pkg::FIRST_DIVISOR);
		// stopping at the square root gives the same verdict
		while (d <= n / d) begin
			if (n % d == 0)
				return 1'b0;
			d++;
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %s: got %0h, expected %0h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// predict the result of one request and queue it
	task automatic queue_prime_result(input logic [tdpc_pkg::IN_W-1:0] v);
		prime_result_t r;
		r.flag = no_divisor_found(v);
		// the tally cannot reach its ceiling in a run this short, but model it anyway
		if (r.flag && prime_count != tdpc_pkg::TALLY_MAX)
			prime_count = prime_count + 1'b1;
		r.total = prime_count;
		result_q.push_back(r);
	endtask

	task automatic send_value(input logic [tdpc_pkg::IN_W-1:0] v);
		int unsigned gap;
		gap = idle_on ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		queue_prime_result(v);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// result side: random stall before each result unless idle_on is clear
	initial begin
		int unsigned gap;
		@(posedge arst_n);
		forever begin
			gap = idle_on ? $urandom_range(0, 19) : 0;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		prime_result_t r;
		if (arst_n && m_tvalid && m_tready) begin
			if (result_q.size() == 0) begin
				report_mismatch("unexpected result", 64'(m_tdata), 64'd0);
			end else begin
				r = result_q.pop_front();
				if (m_tdata[0] !== r.flag)
					report_mismatch("prime_flag", 64'(m_tdata[0]), 64'(r.flag));
				if (m_tdata[32:1] !== r.total)
					report_mismatch("prime_total", 64'(m_tdata[32:1]), 64'(r.total));
				if (m_tdata[tdpc_pkg::OUT_W-1:33] !== '0)
					report_mismatch("padding", 64'(m_tdata[tdpc_pkg::OUT_W-1:33]), 64'd0);
			end
		end
	end

	// zero to five, squares of primes and of 65535, larger primes, bit patterns and the field extremes
	task automatic test_special_values();
		logic [tdpc_pkg::IN_W-1:0] vals[$];
		vals = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49,
			32'd121, 32'd169, 32'd63001, 32'd65521, 32'd65536, 32'd65537,
			32'd1000003, 32'd16777213, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
			32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFE_0001};
		foreach (vals[i])
			send_value(vals[i]);
	endtask

	task automatic test_random_small();
		repeat (25)
			send_value($urandom_range(0, 4095));
	endtask

	task automatic test_random_medium();
		repeat (15)
			send_value($urandom_range(0, (1 << 18) - 1));
	endtask

	// full-width values with a small factor so the divisor loop ends early
	task automatic test_random_wide();
		logic [tdpc_pkg::IN_W-1:0] v;
		int unsigned k;
		repeat (12) begin
			k = $urandom_range(2, 7);
			v = $urandom;
			v = v - v % k;
			send_value(v);
		end
	endtask

	// odd products of two odd factors: the loop runs to the smallest prime factor
	task automatic test_semiprimes();
		logic [tdpc_pkg::IN_W-1:0] p;
		logic [tdpc_pkg::IN_W-1:0] q;
		repeat (10) begin
			p = $urandom_range(50, 300) * 2 + 1;
			q = $urandom_range(1 << 10, (1 << 22) - 1) | 32'd1;
			send_value(p * q);
		end
	endtask

	// no stalls on either side
	task automatic test_back_to_back();
		idle_on = 1'b0;
		repeat (15)
			send_value($urandom_range(0, 1023));
		idle_on = 1'b1;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_values();
		test_random_small();
		test_back_to_back();
		test_random_medium();
		test_random_wide();
		test_semiprimes();
		s_tvalid <= 1'b0;
		while (result_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && result_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
